[rtl/cpp_pkg.sv]
// ----------------------------------------------------------------------------
// cpp_pkg: shared constants and types for the camera point projection
// Fixed-point constants of the camera mount, register indexes, reset values
// and the control words that travel between the pipeline sections.
// ----------------------------------------------------------------------------
package cpp_pkg;

  // fraction bits of the input positions
  localparam int POS_FRAC_BITS = 16;

  // camera mount offset, rounded to the input format
  localparam longint OFF_L_VAL =
    (64'sd51 * (64'sd1 <<< POS_FRAC_BITS) + 64'sd500) / 64'sd1000;
  localparam longint OFF_U_VAL =
    (64'sd1290 * (64'sd1 <<< POS_FRAC_BITS) + 64'sd500) / 64'sd1000;
  localparam logic signed [32:0] OFF_L = 33'(OFF_L_VAL);
  localparam logic signed [32:0] OFF_U = 33'(OFF_U_VAL);

  // cosine and sine of the tilt, Q1.30
  localparam logic signed [30:0] TILT_COS = 31'sd472381087;
  localparam logic signed [30:0] TILT_SIN = 31'sd964249771;

  // divider: one quotient bit per stage
  localparam int DIV_STAGES = 26;
  localparam logic [25:0] NORM_LIMIT = 26'd33554432;

  // register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_K1 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_K2 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_P1 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_P2 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FX = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FY = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CX = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CY = 4'd7;

  // register reset values
  localparam logic signed [31:0] K1_RST = -32'sd307913723;
  localparam logic signed [31:0] K2_RST = 32'sd64297808;
  localparam logic signed [31:0] P1_RST = 32'sd645319;
  localparam logic signed [31:0] P2_RST = -32'sd1828582;
  localparam logic [30:0] FX_RST = 31'd23267075;
  localparam logic [30:0] FY_RST = 31'd23185634;
  localparam logic [30:0] CX_RST = 31'd20073061;
  localparam logic [30:0] CY_RST = 31'd17045041;

  // word attributes entering the divider
  typedef struct packed {
    logic front;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } div_tag_t;

  // word attributes after the divider
  typedef struct packed {
    logic front;
    logic sat;
  } pt_ctl_t;

endpackage

[rtl/camera_point_projection.sv]
// ----------------------------------------------------------------------------
// camera_point_projection: robot-frame point to distorted pixel position
// Tilted pinhole camera with radial and tangential lens distortion.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------
//  input   | in_pos_forward, in_pos_left, in_pos_up  | start & !busy
//  result  | out_pixel_col/row, out_in_front/clipped | out_valid, 1 cycle
//  config  | cfg_index, cfg_data                     | cfg_valid & cfg_ready
//
// One word enters per cycle; each result passes the tilt stages, the 26-stage
// bit-per-stage divider and the distortion and pixel stages. busy stays low
// and cfg_ready stays high.
// Reset clears the valid bits and loads the default camera registers.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module camera_point_projection (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    in_pos_forward,
  input  logic signed [31:0]    in_pos_left,
  input  logic signed [31:0]    in_pos_up,
  output logic                  out_valid,
  output logic signed [15:0]    out_pixel_col,
  output logic signed [15:0]    out_pixel_row,
  output logic                  out_in_front,
  output logic                  out_clipped,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [cpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]           cfg_data
);

  logic signed [31:0] k1_r, k2_r, p1_r, p2_r;
  logic [30:0]        fx_r, fy_r, cx_r, cy_r;

  logic               t_vld;
  cpp_pkg::div_tag_t  t_tag;
  logic [58:0]        t_nx, t_ny;
  logic [34:0]        t_den;

  logic               d_vld;
  cpp_pkg::pt_ctl_t   d_ctl;
  logic signed [26:0] d_xp, d_yp;

  logic               s_vld;
  cpp_pkg::pt_ctl_t   s_ctl;
  logic signed [38:0] s_xpp, s_ypp;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // camera registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r <= cpp_pkg::K1_RST;
      k2_r <= cpp_pkg::K2_RST;
      p1_r <= cpp_pkg::P1_RST;
      p2_r <= cpp_pkg::P2_RST;
      fx_r <= cpp_pkg::FX_RST;
      fy_r <= cpp_pkg::FY_RST;
      cx_r <= cpp_pkg::CX_RST;
      cy_r <= cpp_pkg::CY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cpp_pkg::REG_K1: k1_r <= $signed(cfg_data);
        cpp_pkg::REG_K2: k2_r <= $signed(cfg_data);
        cpp_pkg::REG_P1: p1_r <= $signed(cfg_data);
        cpp_pkg::REG_P2: p2_r <= $signed(cfg_data);
        cpp_pkg::REG_FX: fx_r <= cfg_data[30:0];
        cpp_pkg::REG_FY: fy_r <= cfg_data[30:0];
        cpp_pkg::REG_CX: cx_r <= cfg_data[30:0];
        cpp_pkg::REG_CY: cy_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  cpp_tilt u_tilt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .pos_fwd  (in_pos_forward),
    .pos_left (in_pos_left),
    .pos_up   (in_pos_up),
    .out_vld  (t_vld),
    .out_tag  (t_tag),
    .num_x    (t_nx),
    .num_y    (t_ny),
    .den      (t_den)
  );

  cpp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (t_vld),
    .in_tag  (t_tag),
    .num_x   (t_nx),
    .num_y   (t_ny),
    .den     (t_den),
    .out_vld (d_vld),
    .out_ctl (d_ctl),
    .xp      (d_xp),
    .yp      (d_yp)
  );

  cpp_distort u_distort (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (d_vld),
    .in_ctl  (d_ctl),
    .xp      (d_xp),
    .yp      (d_yp),
    .k1      (k1_r),
    .k2      (k2_r),
    .p1      (p1_r),
    .p2      (p2_r),
    .out_vld (s_vld),
    .out_ctl (s_ctl),
    .xpp     (s_xpp),
    .ypp     (s_ypp)
  );

  cpp_pixel u_pixel (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s_vld),
    .in_ctl   (s_ctl),
    .xpp      (s_xpp),
    .ypp      (s_ypp),
    .focal_x  (fx_r),
    .focal_y  (fy_r),
    .centre_x (cx_r),
    .centre_y (cy_r),
    .out_vld  (out_valid),
    .pix_col  (out_pixel_col),
    .pix_row  (out_pixel_row),
    .front    (out_in_front),
    .clipped  (out_clipped)
  );

endmodule

[rtl/cpp_tilt.sv]
// ----------------------------------------------------------------------------
// cpp_tilt: move the point into the camera frame and prepare the division
// Offset, tilt products, tilt sums and magnitude/overflow preparation in
// four register stages.
// ----------------------------------------------------------------------------
module cpp_tilt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic signed [31:0]      pos_fwd,
  input  logic signed [31:0]      pos_left,
  input  logic signed [31:0]      pos_up,
  output logic                    out_vld,
  output cpp_pkg::div_tag_t       out_tag,
  output logic [58:0]             num_x,
  output logic [58:0]             num_y,
  output logic [34:0]             den
);

  logic [3:0] vld_r;

  logic signed [32:0] xc1_r, yb1_r;
  logic signed [31:0] zb1_r;
  logic signed [32:0] xc2_r;
  logic signed [63:0] cy2_r, sz2_r, sy2_r, cz2_r;
  logic signed [32:0] xc3_r;
  logic signed [34:0] yc3_r, zc3_r;
  logic signed [64:0] dy_nxt, dz_nxt;

  logic [34:0] ax_nxt, ay_nxt;
  logic        front_nxt;

  cpp_pkg::div_tag_t tag_r;
  logic [58:0] nx_r, ny_r;
  logic [34:0] den_r;

  // advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  // stage 1: camera offset
  always_ff @(posedge clk) begin
    xc1_r <= cpp_pkg::OFF_L - pos_left;
    yb1_r <= cpp_pkg::OFF_U - pos_up;
    zb1_r <= pos_fwd;
  end

  // stage 2: tilt products
  always_ff @(posedge clk) begin
    xc2_r <= xc1_r;
    cy2_r <= cpp_pkg::TILT_COS * yb1_r;
    sz2_r <= cpp_pkg::TILT_SIN * zb1_r;
    sy2_r <= cpp_pkg::TILT_SIN * yb1_r;
    cz2_r <= cpp_pkg::TILT_COS * zb1_r;
  end

  // stage 3: tilt sums, back to Q16
  assign dy_nxt = {cy2_r[63], cy2_r} - {sz2_r[63], sz2_r};
  assign dz_nxt = {sy2_r[63], sy2_r} + {cz2_r[63], cz2_r};

  always_ff @(posedge clk) begin
    xc3_r <= xc2_r;
    yc3_r <= $signed(dy_nxt[64:30]);
    zc3_r <= $signed(dz_nxt[64:30]);
  end

  // stage 4: magnitudes, signs and quotient overflow
  always_comb begin
    ax_nxt    = xc3_r[32] ? 35'(-{{2{xc3_r[32]}}, xc3_r}) : 35'({2'b00, xc3_r});
    ay_nxt    = yc3_r[34] ? 35'(-yc3_r) : 35'(yc3_r);
    front_nxt = !zc3_r[34] && (zc3_r != '0);
  end

  always_ff @(posedge clk) begin
    tag_r.front <= front_nxt;
    tag_r.neg_x <= xc3_r[32];
    tag_r.neg_y <= yc3_r[34];
    tag_r.ovf_x <= {2'b00, ax_nxt} >= {zc3_r, 2'b00};
    tag_r.ovf_y <= {2'b00, ay_nxt} >= {zc3_r, 2'b00};
    nx_r        <= {ax_nxt, 24'd0};
    ny_r        <= {ay_nxt, 24'd0};
    den_r       <= zc3_r;
  end

  assign out_vld = vld_r[3];
  assign out_tag = tag_r;
  assign num_x   = nx_r;
  assign num_y   = ny_r;
  assign den     = den_r;

endmodule

[rtl/cpp_div.sv]
// ----------------------------------------------------------------------------
// cpp_div: pipelined restoring divider for both normalised coordinates
// One quotient bit per stage for x and y against the shared depth, then
// sign restore and saturation to +-2.0 in Q.24.
// ----------------------------------------------------------------------------
module cpp_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  cpp_pkg::div_tag_t       in_tag,
  input  logic [58:0]             num_x,
  input  logic [58:0]             num_y,
  input  logic [34:0]             den,
  output logic                    out_vld,
  output cpp_pkg::pt_ctl_t        out_ctl,
  output logic signed [26:0]      xp,
  output logic signed [26:0]      yp
);

  localparam int NS = cpp_pkg::DIV_STAGES;

  logic [NS-1:0]     vld_r;
  cpp_pkg::div_tag_t tag_r [NS];
  logic [58:0]       rx_r  [NS];
  logic [58:0]       ry_r  [NS];
  logic [25:0]       qx_r  [NS];
  logic [25:0]       qy_r  [NS];
  logic [34:0]       den_r [NS];

  cpp_pkg::div_tag_t tag_nxt [NS];
  logic [58:0]       rx_nxt  [NS];
  logic [58:0]       ry_nxt  [NS];
  logic [25:0]       qx_nxt  [NS];
  logic [25:0]       qy_nxt  [NS];
  logic [34:0]       den_nxt [NS];

  logic              vld_o_r;
  cpp_pkg::pt_ctl_t  ctl_r;
  logic signed [26:0] xp_r, yp_r;
  logic              satx, saty;
  logic [25:0]       magx, magy;

  // one quotient bit per stage, most significant first
  always_comb begin
    logic [58:0] rx, ry;
    logic [25:0] qx, qy;
    logic [34:0] d;
    logic [59:0] dsh;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        rx = num_x; ry = num_y; qx = '0; qy = '0; d = den;
        tag_nxt[s] = in_tag;
      end else begin
        rx = rx_r[s-1]; ry = ry_r[s-1]; qx = qx_r[s-1]; qy = qy_r[s-1];
        d = den_r[s-1];
        tag_nxt[s] = tag_r[s-1];
      end
      dsh = {25'd0, d} << (NS - 1 - s);
      if ({1'b0, rx} >= dsh) begin
        rx_nxt[s] = rx - dsh[58:0];
        qx_nxt[s] = {qx[24:0], 1'b1};
      end else begin
        rx_nxt[s] = rx;
        qx_nxt[s] = {qx[24:0], 1'b0};
      end
      if ({1'b0, ry} >= dsh) begin
        ry_nxt[s] = ry - dsh[58:0];
        qy_nxt[s] = {qy[24:0], 1'b1};
      end else begin
        ry_nxt[s] = ry;
        qy_nxt[s] = {qy[24:0], 1'b0};
      end
      den_nxt[s] = d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_o_r <= 1'b0;
    end else begin
      vld_r   <= {vld_r[NS-2:0], in_vld};
      vld_o_r <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      tag_r[s] <= tag_nxt[s];
      rx_r[s]  <= rx_nxt[s];
      ry_r[s]  <= ry_nxt[s];
      qx_r[s]  <= qx_nxt[s];
      qy_r[s]  <= qy_nxt[s];
      den_r[s] <= den_nxt[s];
    end
  end

  // saturate to +-2.0 and restore the sign
  always_comb begin
    satx = tag_r[NS-1].ovf_x || (qx_r[NS-1] > cpp_pkg::NORM_LIMIT);
    saty = tag_r[NS-1].ovf_y || (qy_r[NS-1] > cpp_pkg::NORM_LIMIT);
    magx = satx ? cpp_pkg::NORM_LIMIT : qx_r[NS-1];
    magy = saty ? cpp_pkg::NORM_LIMIT : qy_r[NS-1];
  end

  always_ff @(posedge clk) begin
    xp_r <= tag_r[NS-1].neg_x ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
    yp_r <= tag_r[NS-1].neg_y ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
    ctl_r.front <= tag_r[NS-1].front;
    ctl_r.sat   <= satx || saty;
  end

  assign out_vld = vld_o_r;
  assign out_ctl = ctl_r;
  assign xp      = xp_r;
  assign yp      = yp_r;

endmodule

[rtl/cpp_distort.sv]
// ----------------------------------------------------------------------------
// cpp_distort: radial and tangential lens distortion
// Squares, coefficient products, radial factor and final sums in eight
// register stages, at most one multiplier level per stage.
// ----------------------------------------------------------------------------
module cpp_distort (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  cpp_pkg::pt_ctl_t        in_ctl,
  input  logic signed [26:0]      xp,
  input  logic signed [26:0]      yp,
  input  logic signed [31:0]      k1,
  input  logic signed [31:0]      k2,
  input  logic signed [31:0]      p1,
  input  logic signed [31:0]      p2,
  output logic                    out_vld,
  output cpp_pkg::pt_ctl_t        out_ctl,
  output logic signed [38:0]      xpp,
  output logic signed [38:0]      ypp
);

  logic [7:0]       vld_r;
  cpp_pkg::pt_ctl_t ctl_r [8];

  logic signed [26:0] xp1_r, yp1_r, xp2_r, yp2_r, xp3_r, yp3_r;
  logic signed [26:0] xp4_r, yp4_r, xp5_r, yp5_r, xp6_r, yp6_r;
  logic signed [53:0] xx1_r, yy1_r, xy1_r;
  logic signed [27:0] xxs, yys;
  logic signed [28:0] r2_2_r, r2_3_r, r2_4_r;
  logic signed [27:0] xy2_r;
  logic signed [29:0] sx2_r, sy2_r;
  logic signed [60:0] mk2_r;
  logic signed [59:0] mp1xy_r, mp2xy_r;
  logic signed [61:0] mp2sx_r, mp1sy_r;
  logic signed [31:0] inner_full;
  logic signed [29:0] inner4_r;
  logic signed [32:0] tx4_r, ty4_r, tx5_r, ty5_r, tx6_r, ty6_r, tx7_r, ty7_r;
  logic signed [58:0] min5_r;
  logic signed [34:0] rad6_r;
  logic signed [61:0] mx7_r, my7_r;
  logic signed [38:0] xpp_r, ypp_r;

  // advance valid bits and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[6:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    ctl_r[0] <= in_ctl;
    for (int s = 1; s < 8; s++) begin
      ctl_r[s] <= ctl_r[s-1];
    end
  end

  // stage 1: squares and cross product
  always_ff @(posedge clk) begin
    xx1_r <= xp * xp;
    yy1_r <= yp * yp;
    xy1_r <= xp * yp;
    xp1_r <= xp;
    yp1_r <= yp;
  end

  // stage 2: radius squared and tangential sums
  assign xxs = $signed(xx1_r[51:24]);
  assign yys = $signed(yy1_r[51:24]);

  always_ff @(posedge clk) begin
    r2_2_r <= xxs + yys;
    sx2_r  <= xxs + yys + (xxs <<< 1);
    sy2_r  <= xxs + yys + (yys <<< 1);
    xy2_r  <= $signed(xy1_r[51:24]);
    xp2_r  <= xp1_r;
    yp2_r  <= yp1_r;
  end

  // stage 3: coefficient products
  always_ff @(posedge clk) begin
    mk2_r   <= k2 * r2_2_r;
    mp1xy_r <= p1 * xy2_r;
    mp2xy_r <= p2 * xy2_r;
    mp2sx_r <= p2 * sx2_r;
    mp1sy_r <= p1 * sy2_r;
    r2_3_r  <= r2_2_r;
    xp3_r   <= xp2_r;
    yp3_r   <= yp2_r;
  end

  // stage 4: inner radial term and tangential offsets
  assign inner_full = (k1 >>> 6) + $signed(mk2_r[60:30]);

  always_ff @(posedge clk) begin
    inner4_r <= $signed(inner_full[29:0]);
    tx4_r    <= ($signed(mp1xy_r[59:30]) <<< 1) + $signed(mp2sx_r[61:30]);
    ty4_r    <= $signed(mp1sy_r[61:30]) + ($signed(mp2xy_r[59:30]) <<< 1);
    r2_4_r   <= r2_3_r;
    xp4_r    <= xp3_r;
    yp4_r    <= yp3_r;
  end

  // stage 5: radial product
  always_ff @(posedge clk) begin
    min5_r <= inner4_r * r2_4_r;
    tx5_r  <= tx4_r;
    ty5_r  <= ty4_r;
    xp5_r  <= xp4_r;
    yp5_r  <= yp4_r;
  end

  // stage 6: radial factor
  always_ff @(posedge clk) begin
    rad6_r <= 35'sd16777216 + $signed(min5_r[58:24]);
    tx6_r  <= tx5_r;
    ty6_r  <= ty5_r;
    xp6_r  <= xp5_r;
    yp6_r  <= yp5_r;
  end

  // stage 7: scale by the radial factor
  always_ff @(posedge clk) begin
    mx7_r <= xp6_r * rad6_r;
    my7_r <= yp6_r * rad6_r;
    tx7_r <= tx6_r;
    ty7_r <= ty6_r;
  end

  // stage 8: add tangential offsets
  always_ff @(posedge clk) begin
    xpp_r <= $signed(mx7_r[61:24]) + tx7_r;
    ypp_r <= $signed(my7_r[61:24]) + ty7_r;
  end

  assign out_vld = vld_r[7];
  assign out_ctl = ctl_r[7];
  assign xpp     = xpp_r;
  assign ypp     = ypp_r;

endmodule

[rtl/cpp_pixel.sv]
// ----------------------------------------------------------------------------
// cpp_pixel: focal scaling, principal point and pixel saturation
// Three register stages ending in the result registers.
// ----------------------------------------------------------------------------
module cpp_pixel (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  cpp_pkg::pt_ctl_t        in_ctl,
  input  logic signed [38:0]      xpp,
  input  logic signed [38:0]      ypp,
  input  logic [30:0]             focal_x,
  input  logic [30:0]             focal_y,
  input  logic [30:0]             centre_x,
  input  logic [30:0]             centre_y,
  output logic                    out_vld,
  output logic signed [15:0]      pix_col,
  output logic signed [15:0]      pix_row,
  output logic                    front,
  output logic                    clipped
);

  logic [2:0]       vld_r;
  cpp_pkg::pt_ctl_t ctl1_r, ctl2_r;

  logic signed [62:0] fx1_r, fy1_r;
  logic signed [47:0] cq2_r, rq2_r;
  logic signed [47:0] cadj, radj;
  logic signed [31:0] cp, rp;
  logic               csat_hi, csat_lo, rsat_hi, rsat_lo;
  logic signed [15:0] col_r, row_r;
  logic               front_r, clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  // stage 1: focal products
  always_ff @(posedge clk) begin
    fx1_r  <= $signed({1'b0, focal_x}) * $signed(xpp[38:8]);
    fy1_r  <= $signed({1'b0, focal_y}) * $signed(ypp[38:8]);
    ctl1_r <= in_ctl;
  end

  // stage 2: principal point
  always_ff @(posedge clk) begin
    cq2_r  <= $signed(fx1_r[62:16]) + $signed({1'b0, centre_x});
    rq2_r  <= $signed(fy1_r[62:16]) + $signed({1'b0, centre_y});
    ctl2_r <= ctl1_r;
  end

  // stage 3: truncate toward zero and saturate
  always_comb begin
    cadj    = cq2_r + (cq2_r[47] ? 48'sd65535 : 48'sd0);
    radj    = rq2_r + (rq2_r[47] ? 48'sd65535 : 48'sd0);
    cp      = $signed(cadj[47:16]);
    rp      = $signed(radj[47:16]);
    csat_hi = cp > 32'sd32767;
    csat_lo = cp < -32'sd32768;
    rsat_hi = rp > 32'sd32767;
    rsat_lo = rp < -32'sd32768;
  end

  // drop the pixel fields of a point not in front of the camera
  always_ff @(posedge clk) begin
    front_r <= ctl2_r.front;
    if (!ctl2_r.front) begin
      col_r  <= '0;
      row_r  <= '0;
      clip_r <= 1'b0;
    end else begin
      col_r  <= csat_hi ? 16'sh7fff : (csat_lo ? -16'sh8000 : $signed(cp[15:0]));
      row_r  <= rsat_hi ? 16'sh7fff : (rsat_lo ? -16'sh8000 : $signed(rp[15:0]));
      clip_r <= ctl2_r.sat || csat_hi || csat_lo || rsat_hi || rsat_lo;
    end
  end

  assign out_vld = vld_r[2];
  assign pix_col = col_r;
  assign pix_row = row_r;
  assign front   = front_r;
  assign clipped = clip_r;

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for camera_point_projection
// Sends robot-frame points, predicts each pixel word with a fixed-point
// projection model of its own and checks every result word in order. It
// covers defaults, extremes, points behind the camera, saturation, register
// extremes, ignored register indexes and long random runs under several
// camera settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] col;
    logic signed [15:0] row;
    logic               front;
    logic               clip;
  } pixel_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [31:0]   in_pos_forward = '0;
  logic signed [31:0]   in_pos_left = '0;
  logic signed [31:0]   in_pos_up = '0;
  logic                 out_valid;
  logic signed [15:0]   out_pixel_col;
  logic signed [15:0]   out_pixel_row;
  logic                 out_in_front;
  logic                 out_clipped;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [cpp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  // camera registers as the projection model sees them
  longint cam_k1, cam_k2, cam_p1, cam_p2, cam_fx, cam_fy, cam_cx, cam_cy;

  pixel_word_t pixel_queue[$];
  int          mismatches = 0;
  bit          idling_on = 1'b1;

  camera_point_projection u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // project one point with the current camera registers
  function automatic pixel_word_t project_point(logic signed [31:0] fwd,
                                                logic signed [31:0] lft,
                                                logic signed [31:0] upw);
    pixel_word_t w;
    longint xc, yb, zb, yc, zc, xp, yp, xx, yy, xy, r2, inner, rad;
    longint xpp, ypp, colq, rowq, pc, pr;
    bit     sat;
    w = '{default: '0};
    sat = 1'b0;
    xc = cpp_pkg::OFF_L_VAL - longint'(lft);
    yb = cpp_pkg::OFF_U_VAL - longint'(upw);
    zb = longint'(fwd);
    yc = (longint'(cpp_pkg::TILT_COS) * yb - longint'(cpp_pkg::TILT_SIN) * zb) >>> 30;
    zc = (longint'(cpp_pkg::TILT_SIN) * yb + longint'(cpp_pkg::TILT_COS) * zb) >>> 30;
    if (zc <= 0) return w;
    xp = (xc * (64'sd1 <<< 24)) / zc;
    yp = (yc * (64'sd1 <<< 24)) / zc;
    if (xp > (64'sd1 <<< 25)) begin xp = 64'sd1 <<< 25; sat = 1'b1; end
    if (xp < -(64'sd1 <<< 25)) begin xp = -(64'sd1 <<< 25); sat = 1'b1; end
    if (yp > (64'sd1 <<< 25)) begin yp = 64'sd1 <<< 25; sat = 1'b1; end
    if (yp < -(64'sd1 <<< 25)) begin yp = -(64'sd1 <<< 25); sat = 1'b1; end
    xx = (xp * xp) >>> 24;
    yy = (yp * yp) >>> 24;
    xy = (xp * yp) >>> 24;
    r2 = xx + yy;
    inner = (cam_k1 >>> 6) + ((cam_k2 * r2) >>> 30);
    rad = (64'sd1 <<< 24) + ((inner * r2) >>> 24);
    xpp = ((xp * rad) >>> 24) + 2 * ((cam_p1 * xy) >>> 30)
        + ((cam_p2 * (r2 + 2 * xx)) >>> 30);
    ypp = ((yp * rad) >>> 24) + ((cam_p1 * (r2 + 2 * yy)) >>> 30)
        + 2 * ((cam_p2 * xy) >>> 30);
    colq = ((cam_fx * (xpp >>> 8)) >>> 16) + cam_cx;
    rowq = ((cam_fy * (ypp >>> 8)) >>> 16) + cam_cy;
    // truncate toward zero, then saturate
    pc = colq >= 0 ? colq >>> 16 : -((-colq) >>> 16);
    pr = rowq >= 0 ? rowq >>> 16 : -((-rowq) >>> 16);
    if (pc > 32767) begin pc = 32767; sat = 1'b1; end
    if (pc < -32768) begin pc = -32768; sat = 1'b1; end
    if (pr > 32767) begin pr = 32767; sat = 1'b1; end
    if (pr < -32768) begin pr = -32768; sat = 1'b1; end
    w.col = pc[15:0];
    w.row = pr[15:0];
    w.front = 1'b1;
    w.clip = sat;
    return w;
  endfunction

  // predict on accepted words, update registers on writes, check results
  always @(posedge clk) begin
    pixel_word_t got, exp_w;
    if (!rst_n) begin
      cam_k1 = longint'(cpp_pkg::K1_RST); cam_k2 = longint'(cpp_pkg::K2_RST);
      cam_p1 = longint'(cpp_pkg::P1_RST); cam_p2 = longint'(cpp_pkg::P2_RST);
      cam_fx = longint'(cpp_pkg::FX_RST); cam_fy = longint'(cpp_pkg::FY_RST);
      cam_cx = longint'(cpp_pkg::CX_RST); cam_cy = longint'(cpp_pkg::CY_RST);
    end else begin
      if (out_valid) begin
        got = '{out_pixel_col, out_pixel_row, out_in_front, out_clipped};
        if (pixel_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word col=%0d row=%0d",
                                         got.col, got.row);
        end else begin
          exp_w = pixel_queue.pop_front();
          if (got.col !== exp_w.col || got.row !== exp_w.row ||
              got.front !== exp_w.front || got.clip !== exp_w.clip) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp col=%0d row=%0d front=%0b clip=%0b,",
                       exp_w.col, exp_w.row, exp_w.front, exp_w.clip,
                       " got col=%0d row=%0d front=%0b clip=%0b",
                       got.col, got.row, got.front, got.clip);
          end
        end
      end
      if (start && !busy)
        pixel_queue.insert(pixel_queue.size(),
                           project_point(in_pos_forward, in_pos_left, in_pos_up));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cpp_pkg::REG_K1: cam_k1 = longint'($signed(cfg_data));
          cpp_pkg::REG_K2: cam_k2 = longint'($signed(cfg_data));
          cpp_pkg::REG_P1: cam_p1 = longint'($signed(cfg_data));
          cpp_pkg::REG_P2: cam_p2 = longint'($signed(cfg_data));
          cpp_pkg::REG_FX: cam_fx = longint'(cfg_data[30:0]);
          cpp_pkg::REG_FY: cam_fy = longint'(cfg_data[30:0]);
          cpp_pkg::REG_CX: cam_cx = longint'(cfg_data[30:0]);
          cpp_pkg::REG_CY: cam_cy = longint'(cfg_data[30:0]);
          default: ;
        endcase
      end
    end
  end

  // hold one point on the input until it is taken; start stays high unless an idle gap is drawn
  task automatic send_point(logic [31:0] fwd, logic [31:0] lft, logic [31:0] upw);
    bit taken;
    start <= 1'b1;
    in_pos_forward <= fwd;
    in_pos_left <= lft;
    in_pos_up <= upw;
    do begin
      @(negedge clk);
      taken = start && !busy;
      @(posedge clk);
    end while (!taken);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // drain the pipeline so registers can change
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pixel_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [cpp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      taken = cfg_valid && cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // plausible points, mostly in front of the camera, otherwise raw noise
  task automatic send_random_point();
    if ($urandom_range(0, 9) < 7)
      send_point(32'($urandom_range(0, 40 << 16)) - 32'(2 << 16),
                 32'($urandom_range(0, 20 << 16)) - 32'(10 << 16),
                 32'($urandom_range(0, 8 << 16)) - 32'(3 << 16));
    else
      send_point($urandom, $urandom, $urandom);
  endtask

  task automatic test_defaults();
    repeat (40) send_random_point();
    wait_idle();
  endtask

  task automatic test_directed();
    // field extremes
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_point(32'h80000000, 32'h80000000, 32'h80000000);
    send_point(32'h7fffffff, 32'h80000000, 32'h80000000);
    send_point(32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'hffffffff, 32'hffffffff, 32'hffffffff);
    // point not in front: behind or on the camera plane
    send_point(-32'sd655360, 32'h0, 32'h0);
    send_point(32'h0, 32'h0, 32'(1290 * 65536 / 1000));
    send_point(-32'sd65536, 32'sd65536, 32'sd196608);
    // normalized overflow: far off axis at shallow depth
    send_point(32'sd6554, 32'sd655360, 32'h0);
    send_point(32'sd6554, -32'sd655360, 32'h0);
    send_point(32'sd3000, 32'h0, 32'sd84000);
    send_point(32'sd3000, 32'h0, -32'sd1000000);
    // near the principal axis
    send_point(32'sd131072, 32'sd3342, 32'sd0);
    send_point(32'sd65536, 32'sd3342, 32'sd84541);
    wait_idle();
  endtask

  task automatic test_pixel_overflow();
    write_reg(cpp_pkg::REG_FX, 32'h7fffffff);
    write_reg(cpp_pkg::REG_FY, 32'h7fffffff);
    write_reg(cpp_pkg::REG_CX, 32'h7fffffff);
    write_reg(cpp_pkg::REG_CY, 32'h0);
    repeat (30) send_random_point();
    wait_idle();
  endtask

  task automatic test_register_extremes();
    logic [31:0] lim[3];
    lim = '{32'h80000000, 32'h7fffffff, 32'h0};
    foreach (lim[i]) begin
      write_reg(cpp_pkg::REG_K1, lim[i]);
      write_reg(cpp_pkg::REG_K2, lim[(i + 1) % 3]);
      write_reg(cpp_pkg::REG_P1, lim[(i + 2) % 3]);
      write_reg(cpp_pkg::REG_P2, lim[i]);
      write_reg(cpp_pkg::REG_FX, lim[(i + 1) % 3]);
      write_reg(cpp_pkg::REG_FY, lim[i]);
      write_reg(cpp_pkg::REG_CX, lim[(i + 2) % 3]);
      write_reg(cpp_pkg::REG_CY, lim[(i + 1) % 3]);
      repeat (40) send_random_point();
      wait_idle();
    end
  endtask

  task automatic test_ignored_index();
    for (int idx = 8; idx < 16; idx++)
      write_reg((cpp_pkg::CFG_IDX_W)'(idx), $urandom);
    repeat (20) send_random_point();
    wait_idle();
  endtask

  // random settings, each followed by a run of points
  task automatic test_random_settings(int phases, int per_phase);
    repeat (phases) begin
      write_reg(cpp_pkg::REG_K1,
                $urandom_range(0, 1) ? $urandom : 32'($signed(cpp_pkg::K1_RST)));
      write_reg(cpp_pkg::REG_K2,
                $urandom_range(0, 1) ? $urandom : 32'($signed(cpp_pkg::K2_RST)));
      write_reg(cpp_pkg::REG_P1, $urandom);
      write_reg(cpp_pkg::REG_P2, $urandom);
      write_reg(cpp_pkg::REG_FX,
                $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 1000 << 16)));
      write_reg(cpp_pkg::REG_FY,
                $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 1000 << 16)));
      write_reg(cpp_pkg::REG_CX,
                $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 700 << 16)));
      write_reg(cpp_pkg::REG_CY,
                $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 700 << 16)));
      repeat (per_phase) send_random_point();
      wait_idle();
    end
  endtask

  task automatic test_camera_defaults_back_to_back();
    write_reg(cpp_pkg::REG_K1, 32'($signed(cpp_pkg::K1_RST)));
    write_reg(cpp_pkg::REG_K2, 32'($signed(cpp_pkg::K2_RST)));
    write_reg(cpp_pkg::REG_P1, 32'($signed(cpp_pkg::P1_RST)));
    write_reg(cpp_pkg::REG_P2, 32'($signed(cpp_pkg::P2_RST)));
    write_reg(cpp_pkg::REG_FX, 32'(cpp_pkg::FX_RST));
    write_reg(cpp_pkg::REG_FY, 32'(cpp_pkg::FY_RST));
    write_reg(cpp_pkg::REG_CX, 32'(cpp_pkg::CX_RST));
    write_reg(cpp_pkg::REG_CY, 32'(cpp_pkg::CY_RST));
    idling_on = 1'b0;
    repeat (300) send_random_point();
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_directed();
    test_pixel_overflow();
    test_register_extremes();
    test_ignored_index();
    test_random_settings(10, 100);
    test_camera_defaults_back_to_back();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pixel_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
